// ===== hw/rtl/pgn_pkg.sv =====
// ----------------------------------------------------------------------------
// pgn_pkg: shared types and constants of the gradient noise core
// Opcodes, the queued item record, queue depth and the default permutation.
// ----------------------------------------------------------------------------
package pgn_pkg;

    localparam logic [1:0] OP_RESEED = 2'd0;
    localparam logic [1:0] OP_NOISE1 = 2'd1;
    localparam logic [1:0] OP_NOISE2 = 2'd2;
    localparam logic [1:0] OP_NOISE3 = 2'd3;

    localparam int FRAC_BITS_DEF      = 16;
    localparam int SEED_BYTES_DEF     = 8;
    localparam int SHUFFLE_ROUNDS_DEF = 1024;
    localparam int PERM_ENTRIES       = 256;
    localparam int QUEUE_DEPTH        = 2;

    // one queued transaction, classified by the front end
    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  n_reads;   // table reads of the hash chain
        logic [2:0]  n_mix;     // interpolations
        logic [3:0]  first;     // first read that yields a corner hash
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] cz;
    } item_t;

    localparam logic [7:0] BASE_PERM [PERM_ENTRIES] = '{
        8'h97, 8'hA0, 8'h89, 8'h5B, 8'h5A, 8'h0F, 8'h83, 8'h0D,
        8'hC9, 8'h5F, 8'h60, 8'h35, 8'hC2, 8'hE9, 8'h07, 8'hE1,
        8'h8C, 8'h24, 8'h67, 8'h1E, 8'h45, 8'h8E, 8'h08, 8'h63,
        8'h25, 8'hF0, 8'h15, 8'h0A, 8'h17, 8'hBE, 8'h06, 8'h94,
        8'hF7, 8'h78, 8'hEA, 8'h4B, 8'h00, 8'h1A, 8'hC5, 8'h3E,
        8'h5E, 8'hFC, 8'hDB, 8'hCB, 8'h75, 8'h23, 8'h0B, 8'h20,
        8'h39, 8'hB1, 8'h21, 8'h58, 8'hED, 8'h95, 8'h38, 8'h57,
        8'hAE, 8'h14, 8'h7D, 8'h88, 8'hAB, 8'hA8, 8'h44, 8'hAF,
        8'h4A, 8'hA5, 8'h47, 8'h86, 8'h8B, 8'h30, 8'h1B, 8'hA6,
        8'h4D, 8'h92, 8'h9E, 8'hE7, 8'h53, 8'h6F, 8'hE5, 8'h7A,
        8'h3C, 8'hD3, 8'h85, 8'hE6, 8'hDC, 8'h69, 8'h5C, 8'h29,
        8'h37, 8'h2E, 8'hF5, 8'h28, 8'hF4, 8'h66, 8'h8F, 8'h36,
        8'h41, 8'h19, 8'h3F, 8'hA1, 8'h01, 8'hD8, 8'h50, 8'h49,
        8'hD1, 8'h4C, 8'h84, 8'hBB, 8'hD0, 8'h59, 8'h12, 8'hA9,
        8'hC8, 8'hC4, 8'h87, 8'h82, 8'h74, 8'hBC, 8'h9F, 8'h56,
        8'hA4, 8'h64, 8'h6D, 8'hC6, 8'hAD, 8'hBA, 8'h03, 8'h40,
        8'h34, 8'hD9, 8'hE2, 8'hFA, 8'h7C, 8'h7B, 8'h05, 8'hCA,
        8'h26, 8'h93, 8'h76, 8'h7E, 8'hFF, 8'h52, 8'h55, 8'hD4,
        8'hCF, 8'hCE, 8'h3B, 8'hE3, 8'h2F, 8'h10, 8'h3A, 8'h11,
        8'hB6, 8'hBD, 8'h1C, 8'h2A, 8'hDF, 8'hB7, 8'hAA, 8'hD5,
        8'h77, 8'hF8, 8'h98, 8'h02, 8'h2C, 8'h9A, 8'hA3, 8'h46,
        8'hDD, 8'h99, 8'h65, 8'h9B, 8'hA7, 8'h2B, 8'hAC, 8'h09,
        8'h81, 8'h16, 8'h27, 8'hFD, 8'h13, 8'h62, 8'h6C, 8'h6E,
        8'h4F, 8'h71, 8'hE0, 8'hE8, 8'hB2, 8'hB9, 8'h70, 8'h68,
        8'hDA, 8'hF6, 8'h61, 8'hE4, 8'hFB, 8'h22, 8'hF2, 8'hC1,
        8'hEE, 8'hD2, 8'h90, 8'h0C, 8'hBF, 8'hB3, 8'hA2, 8'hF1,
        8'h51, 8'h33, 8'h91, 8'hEB, 8'hF9, 8'h0E, 8'hEF, 8'h6B,
        8'h31, 8'hC0, 8'hD6, 8'h1F, 8'hB5, 8'hC7, 8'h6A, 8'h9D,
        8'hB8, 8'h54, 8'hCC, 8'hB0, 8'h73, 8'h79, 8'h32, 8'h2D,
        8'h7F, 8'h04, 8'h96, 8'hFE, 8'h8A, 8'hEC, 8'hCD, 8'h5D,
        8'hDE, 8'h72, 8'h43, 8'h1D, 8'h18, 8'h48, 8'hF3, 8'h8D,
        8'h80, 8'hC3, 8'h4E, 8'h42, 8'hD7, 8'h3D, 8'h9C, 8'hB4
    };

endpackage

// ===== hw/rtl/pgn_front.sv =====
// ----------------------------------------------------------------------------
// pgn_front: input acceptance, classification and item queue
// Decodes the opcode into a work plan and buffers items for the engine.
// ----------------------------------------------------------------------------
module pgn_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         opcode,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] coord_y,
    input  logic signed [31:0] coord_z,
    input  logic               hold,
    output logic               itm_valid,
    input  logic               itm_ready,
    output pgn_pkg::item_t     itm
);

    pgn_pkg::item_t entry_reg [pgn_pkg::QUEUE_DEPTH];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    logic           push, pop;
    pgn_pkg::item_t cls;

    always_comb
    begin
        cls.op = opcode;
        cls.cx = coord_x;
        cls.cy = coord_y;
        cls.cz = coord_z;
        case (opcode)
            pgn_pkg::OP_NOISE1:
            begin
                cls.n_reads = 4'd2;  cls.n_mix = 3'd1; cls.first = 4'd0;
            end
            pgn_pkg::OP_NOISE2:
            begin
                cls.n_reads = 4'd6;  cls.n_mix = 3'd3; cls.first = 4'd2;
            end
            pgn_pkg::OP_NOISE3:
            begin
                cls.n_reads = 4'd14; cls.n_mix = 3'd7; cls.first = 4'd6;
            end
            default:
            begin
                cls.n_reads = 4'd0;  cls.n_mix = 3'd0; cls.first = 4'd0;
            end
        endcase
    end

    assign in_stall  = hold || (count_reg == 2'(pgn_pkg::QUEUE_DEPTH));
    assign push      = in_valid && !in_stall;
    assign itm_valid = (count_reg != 2'd0);
    assign pop       = itm_valid && itm_ready;
    assign itm       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hw/rtl/pgn_back.sv =====
// ----------------------------------------------------------------------------
// pgn_back: table engine and arithmetic sequencer
// Owns the permutation RAM, runs table reload/shuffle and noise evaluation.
// ----------------------------------------------------------------------------
module pgn_back #(
    parameter int FRAC_BITS      = pgn_pkg::FRAC_BITS_DEF,
    parameter int SEED_BYTES     = pgn_pkg::SEED_BYTES_DEF,
    parameter int SHUFFLE_ROUNDS = pgn_pkg::SHUFFLE_ROUNDS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [63:0]         seed,
    input  logic                itm_valid,
    output logic                itm_ready,
    input  pgn_pkg::item_t      itm,
    output logic                hold,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [17:0]  noise_value,
    output logic [1:0]          done_kind
);

    localparam int F  = FRAC_BITS;
    localparam int VW = F + 6;
    localparam int MW = F + 7;
    localparam int PW = 2 * MW;
    localparam int SW = VW + 18;
    localparam int IW = $clog2(SEED_BYTES);
    localparam int JW = (SHUFFLE_ROUNDS > 1) ? $clog2(SHUFFLE_ROUNDS) : 1;

    localparam logic signed [VW-1:0] ONE_V  = VW'(1 << F);
    localparam logic signed [VW-1:0] TEN_V  = VW'(10 * (1 << F));
    localparam logic signed [MW-1:0] C15_M  = MW'(15 * (1 << F));
    localparam logic signed [SW-1:0] OUT_HI = SW'(131071);
    localparam logic signed [SW-1:0] OUT_LO = -SW'(131072);
    localparam logic [IW-1:0] BYTE_LAST  = IW'(SEED_BYTES - 1);
    localparam logic [JW-1:0] ROUND_LAST = JW'(SHUFFLE_ROUNDS - 1);

    localparam logic [3:0] ST_INIT = 4'd0;
    localparam logic [3:0] ST_IDLE = 4'd1;
    localparam logic [3:0] ST_SH0  = 4'd2;
    localparam logic [3:0] ST_SH1  = 4'd3;
    localparam logic [3:0] ST_SH2  = 4'd4;
    localparam logic [3:0] ST_SH3  = 4'd5;
    localparam logic [3:0] ST_SH4  = 4'd6;
    localparam logic [3:0] ST_FADE = 4'd7;
    localparam logic [3:0] ST_READ = 4'd8;
    localparam logic [3:0] ST_CAPT = 4'd9;
    localparam logic [3:0] ST_MIX0 = 4'd10;
    localparam logic [3:0] ST_MIX1 = 4'd11;
    localparam logic [3:0] ST_DONE = 4'd12;

    typedef logic signed [VW-1:0] val_t;

    // gradient dot product of one corner
    function automatic val_t grad_dot(input logic [1:0] op, input logic [7:0] h,
                                      input val_t x, input val_t y, input val_t z);
        val_t r;
        begin
            r = '0;
            case (op)
                pgn_pkg::OP_NOISE1: r = h[0] ? x : -x;
                pgn_pkg::OP_NOISE2:
                begin
                    case (h[2:0])
                        3'd0:    r = x + y;
                        3'd1:    r = x;
                        3'd2:    r = x - y;
                        3'd3:    r = -y;
                        3'd4:    r = -x - y;
                        3'd5:    r = -x;
                        3'd6:    r = -x + y;
                        default: r = y;
                    endcase
                end
                default:
                begin
                    case (h[3:0])
                        4'd0:    r = x + y;
                        4'd1:    r = -x + y;
                        4'd2:    r = x - y;
                        4'd3:    r = -x - y;
                        4'd4:    r = x + z;
                        4'd5:    r = -x + z;
                        4'd6:    r = x - z;
                        4'd7:    r = -x - z;
                        4'd8:    r = y + z;
                        4'd9:    r = -y + z;
                        4'd10:   r = y - z;
                        4'd11:   r = -y - z;
                        4'd12:   r = y + x;
                        4'd13:   r = -y + z;
                        4'd14:   r = y - x;
                        default: r = -y - z;
                    endcase
                end
            endcase
            return r;
        end
    endfunction

    // which fade weight a given interpolation uses
    function automatic logic [1:0] mix_axis(input logic [1:0] op, input logic [2:0] mi);
        logic [1:0] a;
        begin
            a = 2'd0;
            case (op)
                pgn_pkg::OP_NOISE2: a = (mi < 3'd2) ? 2'd0 : 2'd1;
                pgn_pkg::OP_NOISE3: a = (mi < 3'd4) ? 2'd0 : ((mi < 3'd6) ? 2'd1 : 2'd2);
                default:            a = 2'd0;
            endcase
            return a;
        end
    endfunction

    // permutation RAM
    logic [7:0] perm_mem [pgn_pkg::PERM_ENTRIES];
    logic [7:0] mem_rd_reg;
    logic       mem_we;
    logic [7:0] mem_wa, mem_wd, mem_ra;

    // control
    logic [3:0]    state_reg, state_next;
    logic [7:0]    cnt_reg, cnt_next;
    logic          reseed_reg, reseed_next;
    logic [IW-1:0] byte_reg, byte_next;
    logic [JW-1:0] round_reg, round_next;
    logic [1:0]    ax_reg, ax_next;
    logic [2:0]    fstep_reg, fstep_next;
    logic [3:0]    rc_reg, rc_next;
    logic [3:0]    qlen_reg, qlen_next;
    logic [2:0]    mi_reg, mi_next;
    logic          out_valid_reg, out_valid_next;

    // datapath
    pgn_pkg::item_t cur_reg;
    logic [7:0]     ib_reg, tmp_reg;
    logic [7:0]     a_reg [2];
    logic [7:0]     bb_reg [4];
    val_t           q_reg [8];
    val_t           fade_reg [3];
    val_t           b_reg;
    logic signed [PW-1:0] mul_reg;
    logic signed [PW-1:0] floor_mul;
    logic signed [MW-1:0] mul_a, mul_b, tx, a6;
    logic signed [17:0]   noise_reg;
    logic [1:0]           kind_reg;

    logic [31:0]  ij_sum, ia_sum;
    logic [7:0]   sb, ia;
    logic [7:0]   x0, x1, y0, y1, z0, z1;
    logic [F-1:0] tsel;
    val_t         fx0, fx1, fy0, fy1, fz0, fz1;
    logic [3:0]   rk, ck_w;
    logic [2:0]   ck;
    val_t         dot_val, mix_res;
    logic [3:0]   qpos;
    logic         load_out, push_dot;
    logic signed [SW-1:0] res_ext;
    logic signed [17:0]   sat_val;

    assign x0 = cur_reg.cx[F+7:F];
    assign y0 = cur_reg.cy[F+7:F];
    assign z0 = cur_reg.cz[F+7:F];
    assign x1 = x0 + 8'd1;
    assign y1 = y0 + 8'd1;
    assign z1 = z0 + 8'd1;

    assign fx0 = $signed({{(VW-F){1'b0}}, cur_reg.cx[F-1:0]});
    assign fy0 = $signed({{(VW-F){1'b0}}, cur_reg.cy[F-1:0]});
    assign fz0 = $signed({{(VW-F){1'b0}}, cur_reg.cz[F-1:0]});
    assign fx1 = fx0 - ONE_V;
    assign fy1 = fy0 - ONE_V;
    assign fz1 = fz0 - ONE_V;

    assign ij_sum = 32'(byte_reg) + 32'(round_reg);
    assign sb     = seed[{byte_reg, 3'b000} +: 8];
    assign ia_sum = 32'(sb) + 32'(round_reg);
    assign ia     = ia_sum[7:0];

    assign tsel = (ax_reg == 2'd0) ? cur_reg.cx[F-1:0] :
                  ((ax_reg == 2'd1) ? cur_reg.cy[F-1:0] : cur_reg.cz[F-1:0]);
    assign tx   = $signed({{(MW-F){1'b0}}, tsel});
    assign a6   = tx + tx + tx + tx + tx + tx - C15_M;
    assign floor_mul = mul_reg >>> F;

    assign rk    = rc_reg - 4'd2;
    assign ck_w  = rc_reg - cur_reg.first;
    assign ck    = ck_w[2:0];
    assign push_dot = (rc_reg >= cur_reg.first);
    assign dot_val  = grad_dot(cur_reg.op, mem_rd_reg,
                               ck[0] ? fx1 : fx0, ck[1] ? fy1 : fy0, ck[2] ? fz1 : fz0);
    assign mix_res  = q_reg[0] + VW'(floor_mul);
    assign qpos     = qlen_reg - 4'd2;

    assign res_ext = SW'(q_reg[0]);
    assign sat_val = (res_ext > OUT_HI) ? 18'(OUT_HI) :
                     ((res_ext < OUT_LO) ? 18'(OUT_LO) : 18'(res_ext));
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    assign itm_ready   = (state_reg == ST_IDLE);
    assign hold        = (state_reg == ST_INIT) && !reseed_reg;
    assign out_valid   = out_valid_reg;
    assign noise_value = noise_reg;
    assign done_kind   = kind_reg;

    // multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == ST_FADE)
        begin
            case (fstep_reg)
                3'd0:
                begin
                    mul_a = tx;  mul_b = a6;
                end
                3'd1:
                begin
                    mul_a = tx;  mul_b = tx;
                end
                3'd2:
                begin
                    mul_a = MW'(floor_mul);  mul_b = tx;
                end
                3'd3:
                begin
                    mul_a = MW'(floor_mul);  mul_b = MW'(b_reg);
                end
                default:
                begin
                    mul_a = '0;  mul_b = '0;
                end
            endcase
        end
        else if (state_reg == ST_MIX0)
        begin
            mul_a = MW'(fade_reg[mix_axis(cur_reg.op, mi_reg)]);
            mul_b = MW'(q_reg[1]) - MW'(q_reg[0]);
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        reseed_next    = reseed_reg;
        byte_next      = byte_reg;
        round_next     = round_reg;
        ax_next        = ax_reg;
        fstep_next     = fstep_reg;
        rc_next        = rc_reg;
        qlen_next      = qlen_reg;
        mi_next        = mi_reg;
        out_valid_next = out_valid_reg && out_stall;
        mem_we = 1'b0;
        mem_wa = '0;
        mem_wd = '0;
        mem_ra = '0;
        case (state_reg)
            ST_INIT:
            begin
                mem_we   = 1'b1;
                mem_wa   = cnt_reg;
                mem_wd   = pgn_pkg::BASE_PERM[cnt_reg];
                cnt_next = cnt_reg + 8'd1;
                if (cnt_reg == 8'd255)
                begin
                    byte_next  = '0;
                    round_next = '0;
                    state_next = reseed_reg ? ST_SH0 : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (itm_valid)
                begin
                    if (itm.op == pgn_pkg::OP_RESEED)
                    begin
                        reseed_next = 1'b1;
                        cnt_next    = '0;
                        state_next  = ST_INIT;
                    end
                    else
                    begin
                        ax_next    = '0;
                        fstep_next = '0;
                        state_next = ST_FADE;
                    end
                end
            end
            ST_SH0:
            begin
                mem_ra     = ij_sum[7:0];
                state_next = ST_SH1;
            end
            ST_SH1:
            begin
                mem_ra     = ia;
                state_next = ST_SH2;
            end
            ST_SH2:
            begin
                mem_ra     = ib_reg;
                state_next = ST_SH3;
            end
            ST_SH3:
            begin
                mem_we     = 1'b1;
                mem_wa     = ia;
                mem_wd     = mem_rd_reg;
                state_next = ST_SH4;
            end
            ST_SH4:
            begin
                mem_we     = 1'b1;
                mem_wa     = ib_reg;
                mem_wd     = tmp_reg;
                state_next = ST_SH0;
                if (round_reg == ROUND_LAST)
                begin
                    round_next = '0;
                    if (byte_reg == BYTE_LAST)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        byte_next = byte_reg + IW'(1);
                    end
                end
                else
                begin
                    round_next = round_reg + JW'(1);
                end
            end
            ST_FADE:
            begin
                fstep_next = fstep_reg + 3'd1;
                if (fstep_reg == 3'd4)
                begin
                    fstep_next = '0;
                    if (ax_reg == cur_reg.op - 2'd1)
                    begin
                        rc_next    = '0;
                        qlen_next  = '0;
                        state_next = ST_READ;
                    end
                    else
                    begin
                        ax_next = ax_reg + 2'd1;
                    end
                end
            end
            ST_READ:
            begin
                if (rc_reg == 4'd0)
                begin
                    mem_ra = x0;
                end
                else if (rc_reg == 4'd1)
                begin
                    mem_ra = x1;
                end
                else if (rc_reg < 4'd6)
                begin
                    mem_ra = a_reg[rk[0]] + (rk[1] ? y1 : y0);
                end
                else
                begin
                    mem_ra = bb_reg[ck[1:0]] + (ck[2] ? z1 : z0);
                end
                state_next = ST_CAPT;
            end
            ST_CAPT:
            begin
                if (push_dot)
                begin
                    qlen_next = qlen_reg + 4'd1;
                end
                if (rc_reg == cur_reg.n_reads - 4'd1)
                begin
                    mi_next    = '0;
                    state_next = ST_MIX0;
                end
                else
                begin
                    rc_next    = rc_reg + 4'd1;
                    state_next = ST_READ;
                end
            end
            ST_MIX0:
            begin
                state_next = ST_MIX1;
            end
            ST_MIX1:
            begin
                qlen_next = qlen_reg - 4'd1;
                if (mi_reg == cur_reg.n_mix - 3'd1)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    mi_next    = mi_reg + 3'd1;
                    state_next = ST_MIX0;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    reseed_next    = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            perm_mem[mem_wa] <= mem_wd;
        end
        mem_rd_reg <= perm_mem[mem_ra];
    end

    always_ff @(posedge clk)
    begin
        mul_reg <= PW'(mul_a) * PW'(mul_b);
        if (state_reg == ST_IDLE && itm_valid)
        begin
            cur_reg <= itm;
        end
        if (state_reg == ST_SH1)
        begin
            ib_reg <= mem_rd_reg;
        end
        if (state_reg == ST_SH2)
        begin
            tmp_reg <= mem_rd_reg;
        end
        if (state_reg == ST_FADE && fstep_reg == 3'd1)
        begin
            b_reg <= VW'(floor_mul) + TEN_V;
        end
        if (state_reg == ST_FADE && fstep_reg == 3'd4)
        begin
            fade_reg[ax_reg] <= VW'(floor_mul);
        end
        if (state_reg == ST_CAPT)
        begin
            if (rc_reg == 4'd0)
            begin
                a_reg[0] <= mem_rd_reg;
            end
            if (rc_reg == 4'd1)
            begin
                a_reg[1] <= mem_rd_reg;
            end
            if (rc_reg >= 4'd2 && rc_reg < 4'd6)
            begin
                bb_reg[rk[1:0]] <= mem_rd_reg;
            end
            if (push_dot)
            begin
                q_reg[qlen_reg[2:0]] <= dot_val;
            end
        end
        if (state_reg == ST_MIX1)
        begin
            for (int i = 0; i < 6; i++)
            begin
                q_reg[i] <= q_reg[i+2];
            end
            q_reg[qpos[2:0]] <= mix_res;
        end
        if (load_out)
        begin
            noise_reg <= reseed_reg ? 18'sd0 : sat_val;
            kind_reg  <= cur_reg.op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            cnt_reg       <= '0;
            reseed_reg    <= 1'b0;
            byte_reg      <= '0;
            round_reg     <= '0;
            ax_reg        <= '0;
            fstep_reg     <= '0;
            rc_reg        <= '0;
            qlen_reg      <= '0;
            mi_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            reseed_reg    <= reseed_next;
            byte_reg      <= byte_next;
            round_reg     <= round_next;
            ax_reg        <= ax_next;
            fstep_reg     <= fstep_next;
            rc_reg        <= rc_next;
            qlen_reg      <= qlen_next;
            mi_reg        <= mi_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hw/rtl/perlin_gradient_noise_core.sv =====
// ----------------------------------------------------------------------------
// perlin_gradient_noise_core: 1D/2D/3D gradient noise over a permutation table
// Flow: one transaction in the engine at a time; it takes the next item from the
//   input queue only when idle, after the dependent table reads (a READ and a
//   CAPT state each) and the fade and lerp steps on the one shared multiplier.
// Reseed: table reload plus one pass through SH0..SH4 per swap, SEED_BYTES x
//   SHUFFLE_ROUNDS swaps.
// Reset: a pass over the table loads the default table; in_stall is high meanwhile.
// ----------------------------------------------------------------------------
module perlin_gradient_noise_core #(
    parameter int FRAC_BITS      = pgn_pkg::FRAC_BITS_DEF,
    parameter int SEED_BYTES     = pgn_pkg::SEED_BYTES_DEF,
    parameter int SHUFFLE_ROUNDS = pgn_pkg::SHUFFLE_ROUNDS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    // input transactions
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         opcode,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] coord_y,
    input  logic signed [31:0] coord_z,
    // result transactions
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [17:0] noise_value,
    output logic [1:0]         done_kind,
    // seed register write
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [63:0]        seed
);

    logic           hold;
    logic           itm_valid;
    logic           itm_ready;
    pgn_pkg::item_t itm;
    logic [63:0]    seed_reg;

    // The user must write the seed only between transactions (the block does not
    // enforce it), so a plain register that always takes the write is enough.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            seed_reg <= seed;
        end
    end

    // Front end: takes transactions, decodes the plan (reads, mixes) and
    // queues them so the input side keeps moving while the engine works.
    pgn_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .coord_x   (coord_x),
        .coord_y   (coord_y),
        .coord_z   (coord_z),
        .hold      (hold),
        .itm_valid (itm_valid),
        .itm_ready (itm_ready),
        .itm       (itm)
    );

    // Back end: table RAM, hash chain, fade and lerp on one multiplier, and
    // the result register that decouples the output side.
    pgn_back #(
        .FRAC_BITS      (FRAC_BITS),
        .SEED_BYTES     (SEED_BYTES),
        .SHUFFLE_ROUNDS (SHUFFLE_ROUNDS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .seed        (seed_reg),
        .itm_valid   (itm_valid),
        .itm_ready   (itm_ready),
        .itm         (itm),
        .hold        (hold),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .noise_value (noise_value),
        .done_kind   (done_kind)
    );

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for perlin_gradient_noise_core
// Streams noise and reseed transactions with random idling and a long output
// hold-off, predicts each result with an in-bench noise model and checks it.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int  FRAC = pgn_pkg::FRAC_BITS_DEF;
    localparam int  NSEED = pgn_pkg::SEED_BYTES_DEF;
    localparam int  ROUNDS = pgn_pkg::SHUFFLE_ROUNDS_DEF;
    localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC;
    localparam int  WATCHDOG_LIMIT = 200000;   // must exceed the length of a full reseed

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } noise_req_t;

    typedef struct packed {
        logic [17:0] value;
        logic [1:0]  kind;
    } noise_res_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         opcode;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic               out_valid;
    logic               out_stall;
    logic signed [17:0] noise_value;
    logic [1:0]         done_kind;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [63:0]        seed;

    perlin_gradient_noise_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .coord_z     (coord_z),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .noise_value (noise_value),
        .done_kind   (done_kind),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .seed        (seed)
    );

    // Model state: permutation table and seed register copy
    logic [7:0]  perm [pgn_pkg::PERM_ENTRIES];
    logic [63:0] seed_reg;

    noise_req_t pending_reqs[$];     // filled by the stimulus, drained by the driver
    noise_res_t expected_results[$];
    int         error_count = 0;
    int         idle_pct_in = 0;     // sender idle percentage
    int         stall_pct_out = 0;   // receiver stall percentage
    int         hold_cycles = 0;     // long output hold-off, counted below
    int         quiet_cycles = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic signed [63:0] fshift(logic signed [63:0] v);
        return v >>> FRAC;   // arithmetic shift is a floor
    endfunction

    function automatic logic signed [63:0] lerp(logic signed [63:0] a,
                                                logic signed [63:0] b,
                                                logic signed [63:0] t);
        return a + fshift(t * (b - a));
    endfunction

    function automatic logic signed [63:0] fade(logic signed [63:0] t);
        logic signed [63:0] a, b, c, d;
        a = 6 * t - 15 * ONE;
        b = fshift(t * a) + 10 * ONE;
        c = fshift(t * t);
        d = fshift(c * t);
        return fshift(d * b);
    endfunction

    function automatic logic [7:0] hash(int i);
        return perm[i & 8'hFF];
    endfunction

    function automatic logic signed [63:0] grad1(logic [7:0] h, logic signed [63:0] x);
        return h[0] ? x : -x;
    endfunction

    function automatic logic signed [63:0] grad2(logic [7:0] h, logic signed [63:0] x,
                                                 logic signed [63:0] y);
        case (h[2:0])
            3'd0: return x + y;
            3'd1: return x;
            3'd2: return x - y;
            3'd3: return -y;
            3'd4: return -x - y;
            3'd5: return -x;
            3'd6: return -x + y;
            default: return y;
        endcase
    endfunction

    // 16 entries, 12 distinct directions; 12 to 15 repeat 0, 9, 1 and 11
    function automatic logic signed [63:0] grad3(logic [7:0] h, logic signed [63:0] x,
                                                 logic signed [63:0] y,
                                                 logic signed [63:0] z);
        case (h[3:0])
            4'd0:  return x + y;
            4'd1:  return -x + y;
            4'd2:  return x - y;
            4'd3:  return -x - y;
            4'd4:  return x + z;
            4'd5:  return -x + z;
            4'd6:  return x - z;
            4'd7:  return -x - z;
            4'd8:  return y + z;
            4'd9:  return -y + z;
            4'd10: return y - z;
            4'd11: return -y - z;
            4'd12: return y + x;
            4'd13: return -y + z;
            4'd14: return y - x;
            default: return -y - z;
        endcase
    endfunction

    task automatic shuffle_table();
        logic [7:0] sb, tmp;
        int ia, ib;
        foreach (perm[i]) perm[i] = pgn_pkg::BASE_PERM[i];
        for (int i = 0; i < NSEED; i++)
        begin
            sb = seed_reg[8*i +: 8];
            for (int j = 0; j < ROUNDS; j++)
            begin
                ia = (sb + j) & 8'hFF;
                ib = perm[(i + j) & 8'hFF];
                tmp = perm[ia];
                perm[ia] = perm[ib];
                perm[ib] = tmp;
            end
        end
    endtask

    task automatic predict_noise(input noise_req_t rq);
        int x0, y0, z0, x1, y1, z1, a0, a1, b00, b01, b10, b11;
        logic signed [63:0] fx0, fy0, fz0, fx1, fy1, fz1, u, v, w, r;
        logic signed [63:0] e0, e1, e00, e10, e01, e11;
        noise_res_t res;
        x0 = rq.x[23:16]; y0 = rq.y[23:16]; z0 = rq.z[23:16];
        x1 = (x0 + 1) & 8'hFF; y1 = (y0 + 1) & 8'hFF; z1 = (z0 + 1) & 8'hFF;
        fx0 = {48'd0, rq.x[15:0]};
        fy0 = {48'd0, rq.y[15:0]};
        fz0 = {48'd0, rq.z[15:0]};
        fx1 = fx0 - ONE; fy1 = fy0 - ONE; fz1 = fz0 - ONE;
        u = fade(fx0); v = fade(fy0); w = fade(fz0);
        r = 0;
        case (rq.op)
            pgn_pkg::OP_RESEED: shuffle_table();
            pgn_pkg::OP_NOISE1: r = lerp(grad1(hash(x0), fx0), grad1(hash(x1), fx1), u);
            pgn_pkg::OP_NOISE2:
            begin
                a0 = hash(x0); a1 = hash(x1);
                e0 = lerp(grad2(hash(a0 + y0), fx0, fy0), grad2(hash(a1 + y0), fx1, fy0), u);
                e1 = lerp(grad2(hash(a0 + y1), fx0, fy1), grad2(hash(a1 + y1), fx1, fy1), u);
                r = lerp(e0, e1, v);
            end
            default:
            begin
                a0 = hash(x0); a1 = hash(x1);
                b00 = hash(a0 + y0); b01 = hash(a0 + y1);
                b10 = hash(a1 + y0); b11 = hash(a1 + y1);
                e00 = lerp(grad3(hash(b00 + z0), fx0, fy0, fz0),
                           grad3(hash(b10 + z0), fx1, fy0, fz0), u);
                e10 = lerp(grad3(hash(b01 + z0), fx0, fy1, fz0),
                           grad3(hash(b11 + z0), fx1, fy1, fz0), u);
                e01 = lerp(grad3(hash(b00 + z1), fx0, fy0, fz1),
                           grad3(hash(b10 + z1), fx1, fy0, fz1), u);
                e11 = lerp(grad3(hash(b01 + z1), fx0, fy1, fz1),
                           grad3(hash(b11 + z1), fx1, fy1, fz1), u);
                r = lerp(lerp(e00, e10, v), lerp(e01, e11, v), w);
            end
        endcase
        if (r > 131071) r = 131071;
        if (r < -131072) r = -131072;
        res.value = r[17:0];
        res.kind = rq.op;
        expected_results.push_back(res);
    endtask

    // ------------------------------------------------------------------
    // Driver: offers the head of the pending queue; the payload holds
    // while stalled, and valid is never lowered while stalled.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            opcode   <= pgn_pkg::OP_NOISE1;
            coord_x  <= '0;
            coord_y  <= '0;
            coord_z  <= '0;
        end
        else
        begin
            // the transaction is taken at this edge, predict it now
            if (in_valid && !in_stall)
            begin
                predict_noise(pending_reqs.pop_front());
            end
            if (!(in_valid && in_stall))
            begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct_in)
                begin
                    in_valid <= 1'b1;
                    opcode   <= pending_reqs[0].op;
                    coord_x  <= pending_reqs[0].x;
                    coord_y  <= pending_reqs[0].y;
                    coord_z  <= pending_reqs[0].z;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random stall, plus a long hold-off to back up the queue
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        noise_res_t exp_res;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual value %0d kind %0d",
                             $time, noise_value, done_kind);
                    error_count++;
                end
                else
                begin
                    exp_res = expected_results.pop_front();
                    if (noise_value !== exp_res.value)
                    begin
                        $display("%0t: noise_value mismatch: expected %0d actual %0d",
                                 $time, $signed(exp_res.value), noise_value);
                        error_count++;
                    end
                    if (done_kind !== exp_res.kind)
                    begin
                        $display("%0t: done_kind mismatch: expected %0d actual %0d",
                                 $time, exp_res.kind, done_kind);
                        error_count++;
                    end
                end
            end
            if (hold_cycles > 0)
            begin
                hold_cycles <= hold_cycles - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < stall_pct_out);
            end
        end
    end

    // Watchdog on cycles without any accepted transaction
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return $urandom();
            1: return {$urandom_range(3) == 0 ? 16'h8000 : 16'h7FFF, 16'($urandom())};
            2: return {16'($urandom_range(0, 3)), 16'($urandom())};
            3: return {16'hFFFF - 16'($urandom_range(3)), 16'($urandom())};
            4: return {16'($urandom()), $urandom_range(1) ? 16'h0000 : 16'hFFFF};
            default: return {16'($urandom_range(255)), 16'($urandom())};
        endcase
    endfunction

    task automatic add_req(logic [1:0] op, logic [31:0] x, logic [31:0] y, logic [31:0] z);
        noise_req_t rq;
        rq.op = op; rq.x = x; rq.y = y; rq.z = z;
        pending_reqs.push_back(rq);
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || expected_results.size() > 0 || in_valid)
            @(posedge clk);
        repeat (80) @(posedge clk);   // longest noise latency, plus margin
    endtask

    task automatic write_seed(logic [63:0] s);
        @(posedge clk);
        cfg_valid <= 1'b1;
        seed      <= s;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        seed_reg = s;
    endtask

    task automatic random_noise(int count);
        logic [1:0] op;
        for (int k = 0; k < count; k++)
        begin
            op = 2'($urandom_range(1, 3));
            add_req(op, rand_coord(), rand_coord(), rand_coord());
        end
    endtask

    initial
    begin
        clk       = 1'b0;
        cfg_valid = 1'b0;
        seed      = '0;
        in_valid  = 1'b0;
        out_stall = 1'b0;
        opcode    = pgn_pkg::OP_NOISE1;
        coord_x   = '0;
        coord_y   = '0;
        coord_z   = '0;
        seed_reg  = '0;
        foreach (perm[i]) perm[i] = pgn_pkg::BASE_PERM[i];
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, every opcode, integer and near-one fractions
        add_req(pgn_pkg::OP_NOISE1, 32'h0000_0000, 32'h0, 32'h0);
        add_req(pgn_pkg::OP_NOISE1, 32'h7FFF_FFFF, 32'h0, 32'h0);
        add_req(pgn_pkg::OP_NOISE1, 32'h8000_0000, 32'h0, 32'h0);
        add_req(pgn_pkg::OP_NOISE1, 32'hFFFF_FFFF, 32'h0, 32'h0);
        add_req(pgn_pkg::OP_NOISE1, 32'h0000_8000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_req(pgn_pkg::OP_NOISE2, 32'h0000_0000, 32'h0000_0000, 32'h0);
        add_req(pgn_pkg::OP_NOISE2, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
        add_req(pgn_pkg::OP_NOISE2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        add_req(pgn_pkg::OP_NOISE2, 32'h00FF_4000, 32'h00FF_C000, 32'h0);
        add_req(pgn_pkg::OP_NOISE3, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        add_req(pgn_pkg::OP_NOISE3, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_req(pgn_pkg::OP_NOISE3, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        add_req(pgn_pkg::OP_NOISE3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_req(pgn_pkg::OP_NOISE3, 32'h0001_8000, 32'hFFFE_8000, 32'h00FF_0001);
        add_req(pgn_pkg::OP_RESEED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);  // zero seed
        add_req(pgn_pkg::OP_NOISE3, 32'h0003_1234, 32'h0005_ABCD, 32'h0007_FFFF);
        wait_drained();

        // Phase 1: seed all ones, no idling
        write_seed(64'hFFFF_FFFF_FFFF_FFFF);
        add_req(pgn_pkg::OP_RESEED, $urandom(), $urandom(), $urandom());
        random_noise(300);
        wait_drained();

        // Phase 2: random seed, sender mostly idle
        write_seed({$urandom(), $urandom()});
        idle_pct_in = 70;
        add_req(pgn_pkg::OP_RESEED, $urandom(), $urandom(), $urandom());
        random_noise(300);
        wait_drained();

        // Phase 3: alternating bytes, receiver mostly stalling, with a long
        // hold-off so the input queue fills and in_stall rises
        write_seed(64'h00FF_00FF_00FF_00FF);
        idle_pct_in = 0;
        stall_pct_out = 70;
        add_req(pgn_pkg::OP_RESEED, 32'h0, 32'h0, 32'h0);
        wait_drained();
        hold_cycles = 400;
        random_noise(350);
        wait_drained();

        // Phase 4: random seed, both sides idling a little
        write_seed({$urandom(), $urandom()});
        idle_pct_in = 11;
        stall_pct_out = 11;
        add_req(pgn_pkg::OP_RESEED, $urandom(), $urandom(), $urandom());
        random_noise(300);
        // then no idling again with a zero seed, which still shuffles the table
        wait_drained();
        write_seed(64'h0);
        idle_pct_in = 0;
        stall_pct_out = 0;
        add_req(pgn_pkg::OP_RESEED, $urandom(), $urandom(), $urandom());
        random_noise(150);
        wait_drained();

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
